FILE: rtl/dtpw_pkg.sv
// Shared types and constants of the depth-tested pixel writer.
// Used by the store, the top level and the port checker; depends on nothing.
package dtpw_pkg;

	localparam int SCREEN_WIDTH  = 256;
	localparam int SCREEN_HEIGHT = 256;
	localparam int PIXELS        = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W        = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic signed [15:0] Z_ONE       = 16'sd16384;
	localparam logic signed [15:0] Z_MINUS_ONE = -16'sd16384;
	localparam logic signed [15:0] Z_FAR       = 16'sd16384;

	localparam logic [1:0] MODE_DRAW  = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_OFFSCREEN = 3'd1;
	localparam logic [2:0] ST_VIEWPORT  = 3'd2;
	localparam logic [2:0] ST_DEPTH     = 3'd3;
	localparam logic [2:0] ST_ZCLIP     = 3'd4;

	typedef enum logic [2:0] {
		REG_VP_LEFT     = 3'd0,
		REG_VP_BOTTOM   = 3'd1,
		REG_VP_WIDTH    = 3'd2,
		REG_VP_HEIGHT   = 3'd3,
		REG_DEPTH_EN    = 3'd4,
		REG_CLEAR_COLOR = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] depth;
		logic [7:0]         red_in;
		logic [7:0]         green_in;
		logic [7:0]         blue_in;
		logic               clear_depth;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [7:0]         red_out;
		logic [7:0]         green_out;
		logic [7:0]         blue_out;
		logic signed [15:0] depth_out;
	} out_item_t;

	// Write request from the test logic to the pixel store.
	typedef struct packed {
		logic               color_we;
		logic               depth_we;
		logic [ADDR_W-1:0]  addr;
		logic [23:0]        color;
		logic signed [15:0] depth;
	} store_wr_t;

endpackage

FILE: rtl/dtpw_store.sv
// Color and depth memories of the pixel writer, with the depth clearing sweep.
// Depends on dtpw_pkg for the screen size and the write request type.
module dtpw_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [dtpw_pkg::ADDR_W-1:0] rd_addr,
	input  dtpw_pkg::store_wr_t        wr,
	output logic [23:0]                rd_color,
	output logic signed [15:0]         rd_depth,
	output logic                       busy
);

	logic [23:0]              color_mem [dtpw_pkg::PIXELS];
	logic signed [15:0]       depth_mem [dtpw_pkg::PIXELS];
	logic [23:0]              rd_color_q;
	logic signed [15:0]       rd_depth_q;
	logic                     clr_busy_q;
	logic [dtpw_pkg::ADDR_W-1:0] clr_cnt_q;

	// After reset every depth entry is swept to far, one entry per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == dtpw_pkg::ADDR_W'(dtpw_pkg::PIXELS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + dtpw_pkg::ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr.color_we) begin
			color_mem[wr.addr] <= wr.color;
		end
		if (rd_en) begin
			rd_color_q <= color_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			depth_mem[clr_cnt_q] <= dtpw_pkg::Z_FAR;
		end else if (wr.depth_we) begin
			depth_mem[wr.addr] <= wr.depth;
		end
		if (rd_en) begin
			rd_depth_q <= depth_mem[rd_addr];
		end
	end

	assign rd_color = rd_color_q;
	assign rd_depth = rd_depth_q;
	assign busy     = clr_busy_q;

endmodule

FILE: rtl/depth_tested_pixel_writer_unit.sv
// Top level of the depth-tested pixel writer: register port, screen and viewport
// checks, depth test and result register. Depends on dtpw_pkg and dtpw_store.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall    in_item  (draw, clear or read)
//   out       output     out_valid / out_stall  out_item (one result per item)
//   config    input      APB psel/penable       paddr, pwdata, prdata
//
// An item is handled in order: the accept edge reads both memories at its pixel;
// the edge at which the result register can take it tests, writes back and loads it.
// The input stays stalled while an item sits between read and write, so two
// items never touch the same pixel in flight.
// After reset the depth memory is swept to far over all SCREEN_WIDTH*SCREEN_HEIGHT
// entries (65536 at 256x256); in_stall is high during the sweep.
// A finished result waits in the output register while the next item is taken.
module depth_tested_pixel_writer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  dtpw_pkg::in_item_t           in_item,
	output logic                         out_valid,
	input  logic                         out_stall,
	output dtpw_pkg::out_item_t          out_item,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dtpw_pkg::PADDR_W-1:0] paddr,
	input  logic [dtpw_pkg::PDATA_W-1:0] pwdata,
	output logic [dtpw_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	logic signed [15:0] vp_left_q;
	logic signed [15:0] vp_bottom_q;
	logic [15:0]        vp_width_q;
	logic [15:0]        vp_height_q;
	logic               depth_en_q;
	logic [23:0]        clear_color_q;

	logic                reg_we;
	dtpw_pkg::reg_idx_t  reg_idx;

	logic                       store_busy;
	logic                       accept;
	logic                       fire;
	logic                       onscr_c;
	logic                       inview_c;
	logic                       zok_c;
	logic [31:0]                addr_full_c;
	logic [dtpw_pkg::ADDR_W-1:0] addr_c;
	logic signed [17:0]         x_ext;
	logic signed [17:0]         y_ext;
	logic signed [17:0]         left_ext;
	logic signed [17:0]         bottom_ext;
	logic signed [17:0]         right_ext;
	logic signed [17:0]         top_ext;

	logic                       valid_s1;
	dtpw_pkg::in_item_t         item_s1;
	logic                       onscr_s1;
	logic                       inview_s1;
	logic                       zok_s1;
	logic [dtpw_pkg::ADDR_W-1:0] addr_s1;

	logic [23:0]                rd_color;
	logic signed [15:0]         rd_depth;
	dtpw_pkg::store_wr_t        wr;
	dtpw_pkg::out_item_t        res_c;

	logic                       out_valid_q;
	dtpw_pkg::out_item_t        out_item_q;

	// Configuration registers.
	assign pready  = 1'b1;
	assign reg_we  = psel && penable && pwrite;
	assign reg_idx = dtpw_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_left_q     <= '0;
			vp_bottom_q   <= '0;
			vp_width_q    <= 16'd256;
			vp_height_q   <= 16'd256;
			depth_en_q    <= 1'b0;
			clear_color_q <= 24'hFFFFFF;
		end else if (reg_we) begin
			case (reg_idx)
				dtpw_pkg::REG_VP_LEFT:     vp_left_q     <= pwdata[15:0];
				dtpw_pkg::REG_VP_BOTTOM:   vp_bottom_q   <= pwdata[15:0];
				dtpw_pkg::REG_VP_WIDTH:    vp_width_q    <= pwdata[15:0];
				dtpw_pkg::REG_VP_HEIGHT:   vp_height_q   <= pwdata[15:0];
				dtpw_pkg::REG_DEPTH_EN:    depth_en_q    <= pwdata[0];
				dtpw_pkg::REG_CLEAR_COLOR: clear_color_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dtpw_pkg::REG_VP_LEFT:     prdata = {16'b0, vp_left_q};
			dtpw_pkg::REG_VP_BOTTOM:   prdata = {16'b0, vp_bottom_q};
			dtpw_pkg::REG_VP_WIDTH:    prdata = {16'b0, vp_width_q};
			dtpw_pkg::REG_VP_HEIGHT:   prdata = {16'b0, vp_height_q};
			dtpw_pkg::REG_DEPTH_EN:    prdata = {31'b0, depth_en_q};
			dtpw_pkg::REG_CLEAR_COLOR: prdata = {8'b0, clear_color_q};
			default:                   prdata = '0;
		endcase
	end

	// Input side: checks that need no stored data are done before the read.
	assign in_stall = store_busy || valid_s1;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		x_ext      = $signed({{2{in_item.pos_x[15]}}, in_item.pos_x});
		y_ext      = $signed({{2{in_item.pos_y[15]}}, in_item.pos_y});
		left_ext   = $signed({{2{vp_left_q[15]}}, vp_left_q});
		bottom_ext = $signed({{2{vp_bottom_q[15]}}, vp_bottom_q});
		// Eighteen bits hold the far edges without wrap.
		right_ext  = left_ext + $signed({2'b00, vp_width_q});
		top_ext    = bottom_ext + $signed({2'b00, vp_height_q});

		onscr_c  = !in_item.pos_x[15] && (in_item.pos_x[14:0] < 15'(dtpw_pkg::SCREEN_WIDTH))
			&& !in_item.pos_y[15] && (in_item.pos_y[14:0] < 15'(dtpw_pkg::SCREEN_HEIGHT));
		inview_c = (x_ext >= left_ext) && (x_ext < right_ext)
			&& (y_ext >= bottom_ext) && (y_ext < top_ext);
		zok_c    = (in_item.depth >= dtpw_pkg::Z_MINUS_ONE) && (in_item.depth <= dtpw_pkg::Z_ONE);

		addr_full_c = 32'(in_item.pos_y[14:0]) * 32'(dtpw_pkg::SCREEN_WIDTH)
			+ 32'(in_item.pos_x[14:0]);
		addr_c      = addr_full_c[dtpw_pkg::ADDR_W-1:0];
	end

	dtpw_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (addr_c),
		.wr       (wr),
		.rd_color (rd_color),
		.rd_depth (rd_depth),
		.busy     (store_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1   <= in_item;
			onscr_s1  <= onscr_c;
			inview_s1 <= inview_c;
			zok_s1    <= zok_c;
			addr_s1   <= addr_c;
		end
	end

	// Test and write back once the result register can take the result.
	assign fire = valid_s1 && (!out_valid_q || !out_stall);

	always_comb begin
		wr.color_we = 1'b0;
		wr.depth_we = 1'b0;
		wr.addr     = addr_s1;
		wr.color    = {item_s1.red_in, item_s1.green_in, item_s1.blue_in};
		wr.depth    = item_s1.depth;
		res_c       = '0;
		res_c.status = dtpw_pkg::ST_OK;
		case (item_s1.mode)
			dtpw_pkg::MODE_DRAW: begin
				if (!onscr_s1) begin
					res_c.status = dtpw_pkg::ST_OFFSCREEN;
				end else if (!inview_s1) begin
					res_c.status = dtpw_pkg::ST_VIEWPORT;
				end else if (depth_en_q && !(item_s1.depth < rd_depth)) begin
					res_c.status = dtpw_pkg::ST_DEPTH;
				end else if (!zok_s1) begin
					res_c.status = dtpw_pkg::ST_ZCLIP;
				end else begin
					wr.color_we = fire;
					wr.depth_we = fire && depth_en_q;
				end
			end
			dtpw_pkg::MODE_CLEAR: begin
				wr.color = clear_color_q;
				wr.depth = dtpw_pkg::Z_FAR;
				if (!onscr_s1) begin
					res_c.status = dtpw_pkg::ST_OFFSCREEN;
				end else begin
					// The depth reset ignores the viewport and the depth enable.
					wr.depth_we = fire && item_s1.clear_depth;
					if (!inview_s1) begin
						res_c.status = dtpw_pkg::ST_VIEWPORT;
					end else begin
						wr.color_we = fire;
					end
				end
			end
			dtpw_pkg::MODE_READ: begin
				if (!onscr_s1) begin
					res_c.status = dtpw_pkg::ST_OFFSCREEN;
				end else begin
					res_c.red_out   = rd_color[23:16];
					res_c.green_out = rd_color[15:8];
					res_c.blue_out  = rd_color[7:0];
					res_c.depth_out = rd_depth;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

FILE: rtl/dtpw_checker.sv
// Port-level checks of the depth-tested pixel writer and their bind to the top.
// Depends on dtpw_pkg for the payload types and status codes.
module dtpw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input dtpw_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_stall,
	input dtpw_pkg::out_item_t out_item
);

	// A result that is not taken stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed or vanished");

	// Only one item is between read and write at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in flight");

	// An accepted item reaches the result register as soon as it is free.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !(out_valid && out_stall) |=> out_valid)
		else $error("accepted item produced no result");

	// A failed item carries no color or depth.
	a_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.status != dtpw_pkg::ST_OK) |->
			(out_item.red_out == 8'd0) && (out_item.green_out == 8'd0)
			&& (out_item.blue_out == 8'd0) && (out_item.depth_out == 16'sd0))
		else $error("failed item returned pixel data");

endmodule

bind depth_tested_pixel_writer_unit dtpw_checker u_dtpw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
